// ----- rtl/core/kspm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kspm_pkg: shared definitions for the key sequence prefix matcher
// Item mode codes, default sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package kspm_pkg;

  // Default table geometry.
  localparam int DEF_MAX_ENTRIES = 32;
  localparam int DEF_MAX_SEQ_LEN = 8;

  // Timeout register value after reset, in tick items.
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // Input item modes.
  localparam logic [1:0] MODE_KEY  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INFO,
    ST_CHECK
  } kspm_state_t;

endpackage : kspm_pkg
`default_nettype wire

// ----- rtl/core/kspm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kspm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kspm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : kspm_ram
`default_nettype wire

// ----- rtl/core/key_sequence_prefix_matcher_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_sequence_prefix_matcher_core: escape sequence to key code decoder
// Builds a table of byte sequences from load items and maps received key
// bytes to target codes by an in-order prefix search over that table.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                       Transfer when
//  --------  --------------------------------------------  -----------------
//  item in   start, busy, mode, data_byte, target_code,    start && !busy
//            entry_end
//  result    key_valid, key_code, from_table               key_valid (1 cycle)
//  config    cfg_we, cfg_wdata (timeout_ticks)             cfg_we
//
//  Load items, tick items and zero key bytes finish in the cycle of their
//  transfer; busy stays low. A nonzero key byte holds busy while the search
//  visits each candidate entry in turn and compares its bytes, and while it
//  finds that no entry matches. key_valid rises in the cycle in which busy
//  falls and lasts one cycle; the receiver cannot stall it. Synchronous
//  reset empties the table and idles the matcher.
//
module key_sequence_prefix_matcher_core
  import kspm_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_SEQ_LEN = DEF_MAX_SEQ_LEN
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Item channel.
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  target_code,
  input  wire logic        entry_end,
  // Result channel.
  output logic             key_valid,
  output logic [7:0]       key_code,
  output logic             from_table,
  // Configuration: timeout_ticks.
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  // Entry index width, entry count width, byte index width and length width.
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int JW = $clog2(MAX_SEQ_LEN);
  localparam int PW = $clog2(MAX_SEQ_LEN + 1);
  // Each entry owns a power-of-two row in the sequence store, so the store
  // address is simply the entry index next to the byte index.
  localparam int STORE_DEPTH = MAX_ENTRIES * (2 ** JW);
  localparam int INFO_W = JW + 8;

  // Sequencer and search registers.
  kspm_state_t   state, state_next;
  logic [CW-1:0] cand, cand_next;
  logic [CW-1:0] hit, hit_next;
  logic [JW-1:0] jpos, jpos_next;
  logic [PW-1:0] len, len_next;

  // Matcher state.
  logic [PW-1:0] mpos, mpos_next;
  logic [15:0]   wait_cnt, wait_cnt_next;
  logic [7:0]    last_byte, last_byte_next;
  logic [7:0]    match_buffer [MAX_SEQ_LEN];
  logic          buf_we;

  // Table build state.
  logic [CW-1:0] entry_count, entry_count_next;
  logic [JW-1:0] build_pos, build_pos_next;

  // Configuration.
  logic [15:0]   timeout;

  // Result registers.
  logic          key_valid_next;
  logic [7:0]    key_code_next;
  logic          from_table_next;

  // RAM ports.
  logic                 store_we;
  logic [EW+JW-1:0]     store_waddr;
  logic [EW+JW-1:0]     store_raddr;
  logic [7:0]           store_rdata;
  logic                 info_we;
  logic [INFO_W-1:0]    info_wdata;
  logic [INFO_W-1:0]    info_rdata;
  logic [JW-1:0]        info_len;
  logic [7:0]           info_target;

  // Helpers.
  logic                 accept;
  logic [15:0]          wait_inc;
  logic [JW-1:0]        kept;
  logic                 mismatch;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign info_len    = info_rdata[INFO_W-1:8];
  assign info_target = info_rdata[7:0];

  // Sequence bytes of every entry, one row per entry.
  kspm_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (data_byte),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Length and target code of every committed entry.
  kspm_ram #(
    .WIDTH (INFO_W),
    .DEPTH (MAX_ENTRIES)
  ) u_info (
    .clk   (clk),
    .we    (info_we),
    .waddr (entry_count[EW-1:0]),
    .wdata (info_wdata),
    .raddr (cand[EW-1:0]),
    .rdata (info_rdata)
  );

  assign store_waddr = {entry_count[EW-1:0], build_pos};

  // The read address runs one byte ahead of the compare, so that each
  // compare finds its byte in the registered RAM output.
  always_comb begin
    if (state == ST_CHECK) begin
      store_raddr = {cand[EW-1:0], jpos + JW'(1)};
    end else begin
      store_raddr = {cand[EW-1:0], {JW{1'b0}}};
    end
  end

  // Saturating tick count and the number of bytes a load keeps.
  assign wait_inc = (wait_cnt == 16'hFFFF) ? wait_cnt : wait_cnt + 16'd1;
  assign kept     = (build_pos < JW'(MAX_SEQ_LEN - 1)) ? build_pos + JW'(1) : build_pos;

  // The candidate fails if it is too short or if the current byte differs.
  assign mismatch = (PW'(info_len) < len) || (store_rdata != match_buffer[jpos]);

  always_comb begin
    state_next       = state;
    cand_next        = cand;
    hit_next         = hit;
    jpos_next        = jpos;
    len_next         = len;
    mpos_next        = mpos;
    wait_cnt_next    = wait_cnt;
    last_byte_next   = last_byte;
    entry_count_next = entry_count;
    build_pos_next   = build_pos;
    key_valid_next   = 1'b0;
    key_code_next    = key_code;
    from_table_next  = from_table;
    buf_we           = 1'b0;
    store_we         = 1'b0;
    info_we          = 1'b0;
    info_wdata       = {kept, target_code};

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_KEY: begin
              if (data_byte == 8'd0) begin
                // A zero byte aborts a pending sequence, or passes through.
                key_valid_next  = 1'b1;
                from_table_next = 1'b0;
                key_code_next   = (mpos == '0) ? 8'd0 : last_byte;
                mpos_next       = '0;
                wait_cnt_next   = '0;
              end else begin
                // Entries before the last hit cannot match a longer buffer,
                // so a continuing sequence resumes there.
                buf_we         = 1'b1;
                last_byte_next = data_byte;
                len_next       = mpos + PW'(1);
                cand_next      = (mpos == '0) ? '0 : hit;
                state_next     = ST_INFO;
              end
            end
            MODE_TICK: begin
              if (mpos != '0) begin
                wait_cnt_next = wait_inc;
                if (wait_inc >= timeout) begin
                  key_valid_next  = 1'b1;
                  from_table_next = 1'b0;
                  key_code_next   = last_byte;
                  mpos_next       = '0;
                  wait_cnt_next   = '0;
                end
              end
            end
            MODE_LOAD: begin
              if (entry_count < CW'(MAX_ENTRIES)) begin
                store_we = (build_pos < JW'(MAX_SEQ_LEN - 1));
                if (entry_end) begin
                  info_we          = 1'b1;
                  entry_count_next = entry_count + CW'(1);
                  build_pos_next   = '0;
                end else begin
                  build_pos_next = kept;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_INFO: begin
        if (cand >= entry_count) begin
          // No entry matches: the new byte goes out raw.
          key_valid_next  = 1'b1;
          from_table_next = 1'b0;
          key_code_next   = last_byte;
          mpos_next       = '0;
          wait_cnt_next   = '0;
          state_next      = ST_IDLE;
        end else begin
          jpos_next  = '0;
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (mismatch) begin
          cand_next  = cand + CW'(1);
          state_next = ST_INFO;
        end else if (PW'(jpos) == len - PW'(1)) begin
          state_next = ST_IDLE;
          if (PW'(info_len) == len) begin
            key_valid_next  = 1'b1;
            from_table_next = 1'b1;
            key_code_next   = info_target;
            mpos_next       = '0;
            wait_cnt_next   = '0;
          end else if (len == PW'(MAX_SEQ_LEN)) begin
            key_valid_next  = 1'b1;
            from_table_next = 1'b0;
            key_code_next   = last_byte;
            mpos_next       = '0;
            wait_cnt_next   = '0;
          end else begin
            // Prefix of a longer entry: wait for the next byte.
            mpos_next     = len;
            wait_cnt_next = '0;
            hit_next      = cand;
          end
        end else begin
          jpos_next = jpos + JW'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mpos        <= '0;
      wait_cnt    <= '0;
      last_byte   <= '0;
      entry_count <= '0;
      build_pos   <= '0;
      hit         <= '0;
      key_valid   <= 1'b0;
      timeout     <= TIMEOUT_RESET;
    end else begin
      state       <= state_next;
      mpos        <= mpos_next;
      wait_cnt    <= wait_cnt_next;
      last_byte   <= last_byte_next;
      entry_count <= entry_count_next;
      build_pos   <= build_pos_next;
      hit         <= hit_next;
      key_valid   <= key_valid_next;
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
    end
  end

  // Search working registers and result payload.
  always_ff @(posedge clk) begin
    cand       <= cand_next;
    jpos       <= jpos_next;
    len        <= len_next;
    key_code   <= key_code_next;
    from_table <= from_table_next;
    if (buf_we) begin
      match_buffer[mpos[JW-1:0]] <= data_byte;
    end
  end

endmodule : key_sequence_prefix_matcher_core
`default_nettype wire

// ----- rtl/core/kspm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kspm_checker: port-level checks for the key sequence prefix matcher
// Watches the item and result ports and flags impossible sequences.
// ----------------------------------------------------------------------------
module kspm_checker
  import kspm_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] mode,
  input wire logic [7:0] data_byte,
  input wire logic       key_valid,
  input wire logic       from_table
);

  // Results only appear once the search has finished.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> !busy)
    else $error("result transfer while a search is running");

  // A zero key byte always yields a raw result in the next cycle.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_KEY && data_byte == 8'd0)
      |=> (key_valid && !from_table && !busy))
    else $error("zero key byte did not produce a raw result");

  // Load items never produce a result and never start a search.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_LOAD) |=> (!key_valid && !busy))
    else $error("load item produced a result or made the block busy");

  // Tick items complete at once; a table hit is never caused by one.
  a_tick_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_TICK) |=> (!busy && !(key_valid && from_table)))
    else $error("tick item started a search or produced a table code");

  // Leaving reset, the block is idle.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !key_valid))
    else $error("block not idle after reset");

endmodule : kspm_checker

bind key_sequence_prefix_matcher_core kspm_checker u_kspm_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .mode       (mode),
  .data_byte  (data_byte),
  .key_valid  (key_valid),
  .from_table (from_table)
);
`default_nettype wire

// ----- dv/tb_key_sequence_prefix_matcher_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_key_sequence_prefix_matcher_core: self-checking bench for the key decoder
// Builds escape sequence tables through load items and plays key bytes and
// tick items under several timeout settings and sender gap rates. Every key
// code transfer is checked against an in-bench model of the prefix search.
// ----------------------------------------------------------------------------
module tb_key_sequence_prefix_matcher_core;
  import kspm_pkg::*;

  localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
  localparam int MAX_SEQ_LEN = DEF_MAX_SEQ_LEN;

  // The fourth mode code has no meaning; the core must drop such items.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Random items per phase, at least 1025 in total over five phases.
  localparam int PHASE_ITEMS = 205;

  // A worst case search visits every entry and compares every byte of it.
  localparam int SETTLE_CYCLES = MAX_ENTRIES * (MAX_SEQ_LEN + 1) + 8;
  localparam int LIMIT_CYCLES  = 1_500_000;
  localparam int MAX_REPORTS   = 40;

  // Bytes that show up in real terminal sequences, so that random entries
  // share prefixes often and the in-order search has shadowing to resolve.
  localparam logic [63:0] SEQ_ALPHABET = 64'h5B4F31327E41421B;

  typedef struct packed {
    logic [1:0] md;
    logic [7:0] data;
    logic [7:0] target;
    logic       commit;
  } key_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic       hit;
  } key_result_t;

  // Every input of the core holds a known value from time zero.
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic        busy;
  logic [1:0]  mode        = MODE_KEY;
  logic [7:0]  data_byte   = 8'h00;
  logic [7:0]  target_code = 8'h00;
  logic        entry_end   = 1'b0;
  logic        key_valid;
  logic [7:0]  key_code;
  logic        from_table;
  logic        cfg_we      = 1'b0;
  logic [15:0] cfg_wdata   = 16'h0000;

  key_sequence_prefix_matcher_core #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .data_byte   (data_byte),
    .target_code (target_code),
    .entry_end   (entry_end),
    .key_valid   (key_valid),
    .key_code    (key_code),
    .from_table  (from_table),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  // 4 ns clock, low half first.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model. It is advanced once per accepted item transfer, in
  // transfer order, and appends the key code it predicts to expected_keys.
  // --------------------------------------------------------------------------
  logic [7:0]  seq_ram [MAX_ENTRIES][MAX_SEQ_LEN];
  logic [3:0]  seq_len [MAX_ENTRIES];
  logic [7:0]  seq_code [MAX_ENTRIES];
  int          seq_total   = 0;
  int          load_pos    = 0;
  logic [7:0]  rx_buf [MAX_SEQ_LEN];
  int          rx_len      = 0;
  logic [15:0] idle_ticks  = 16'h0000;
  logic [7:0]  rx_last     = 8'h00;
  logic [15:0] timeout_reg = TIMEOUT_RESET;
  key_result_t expected_keys[$];

  // Any emitted key code ends the pending sequence.
  function automatic void push_key_code(input logic [7:0] code, input logic hit);
    key_result_t r;
    r.code = code;
    r.hit  = hit;
    expected_keys.push_back(r);
    rx_len     = 0;
    idle_ticks = 16'h0000;
  endfunction

  function automatic void predict_item(input logic [1:0] md, input logic [7:0] b,
                                       input logic [7:0] tgt, input logic last_b);
    int hit;
    int len;
    bit same;
    case (md)
      MODE_KEY: begin
        if (b == 8'h00) begin
          // A zero byte is never searched. Idle, it comes out as itself;
          // in the middle of a sequence it flushes the last byte instead.
          push_key_code((rx_len == 0) ? 8'h00 : rx_last, 1'b0);
        end else begin
          if (rx_len >= MAX_SEQ_LEN) rx_len = 0;
          rx_buf[rx_len] = b;
          rx_last        = b;
          len            = rx_len + 1;
          // First entry in load order whose opening bytes equal the buffer.
          hit = -1;
          for (int i = 0; i < seq_total && hit < 0; i++) begin
            same = (seq_len[i] >= len);
            for (int j = 0; same && j < len; j++) begin
              if (seq_ram[i][j] != rx_buf[j]) same = 1'b0;
            end
            if (same) hit = i;
          end
          if (hit < 0) begin
            push_key_code(b, 1'b0);
          end else if (seq_len[hit] == len) begin
            push_key_code(seq_code[hit], 1'b1);
          end else if (len >= MAX_SEQ_LEN) begin
            push_key_code(b, 1'b0);
          end else begin
            rx_len     = len;
            idle_ticks = 16'h0000;
          end
        end
      end
      MODE_TICK: begin
        // Ticks only count while a sequence is pending. A timeout of zero
        // acts as one because the count is raised before the compare.
        if (rx_len != 0) begin
          if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
          if (idle_ticks >= timeout_reg) push_key_code(rx_last, 1'b0);
        end
      end
      MODE_LOAD: begin
        // Bytes past the longest entry are dropped, but the commit still
        // counts. Once the table is full, loads have no effect at all.
        if (seq_total < MAX_ENTRIES) begin
          if (load_pos < MAX_SEQ_LEN - 1) begin
            seq_ram[seq_total][load_pos] = b;
            load_pos++;
          end
          if (last_b) begin
            seq_len[seq_total]  = 4'(load_pos);
            seq_code[seq_total] = tgt;
            seq_total++;
            load_pos = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation. The generator keeps its own catalog of the entries
  // it has loaded so that it can replay them, whole or cut short, as key
  // byte sequences with random gaps and endings.
  // --------------------------------------------------------------------------
  logic [7:0] cat_bytes [MAX_ENTRIES][MAX_SEQ_LEN];
  int         cat_len [MAX_ENTRIES];
  int         cat_total = 0;
  logic [7:0] draft [MAX_SEQ_LEN + 2];
  key_item_t  item_q[$];
  int         idle_pct = 0;

  function automatic void queue_item(input logic [1:0] md, input logic [7:0] b,
                                     input logic [7:0] tgt, input logic last_b);
    key_item_t it;
    it.md     = md;
    it.data   = b;
    it.target = tgt;
    it.commit = last_b;
    item_q.push_back(it);
  endfunction

  // Queues the first n draft bytes as one entry, committed on the last one.
  function automatic void queue_entry(input int n, input logic [7:0] tgt);
    for (int i = 0; i < n; i++) begin
      queue_item(MODE_LOAD, draft[i], (i == n - 1) ? tgt : 8'($urandom), i == n - 1);
    end
    if (cat_total < MAX_ENTRIES) begin
      cat_len[cat_total] = (n < MAX_SEQ_LEN) ? n : MAX_SEQ_LEN - 1;
      for (int i = 0; i < cat_len[cat_total]; i++) cat_bytes[cat_total][i] = draft[i];
      cat_total++;
    end
  endfunction

  // Fills the draft from a constant whose first byte is the most significant.
  function automatic void set_draft(input logic [79:0] bytes, input int n);
    for (int i = 0; i < n; i++) draft[i] = bytes[8 * (n - 1 - i) +: 8];
  endfunction

  // Composes a random entry in the draft and returns its length. Half of
  // them extend a prefix of an entry already in the catalog.
  function automatic int compose_entry(input int max_len);
    int n;
    int k;
    int keep;
    if (max_len > MAX_SEQ_LEN - 1 && $urandom_range(9) == 0) begin
      n = $urandom_range(MAX_SEQ_LEN + 1, MAX_SEQ_LEN);
    end else begin
      n = $urandom_range((max_len < MAX_SEQ_LEN - 1) ? max_len : MAX_SEQ_LEN - 1, 1);
    end
    keep = 0;
    if (cat_total > 0 && $urandom_range(1) == 0) begin
      k    = $urandom_range(cat_total - 1);
      keep = $urandom_range(cat_len[k]);
      if (keep > n) keep = n;
      for (int i = 0; i < keep; i++) draft[i] = cat_bytes[k][i];
    end
    for (int i = keep; i < n; i++) begin
      if (i == 0) begin
        draft[i] = ($urandom_range(9) < 6) ? 8'h1B : 8'($urandom_range(255, 1));
      end else if ($urandom_range(24) == 0) begin
        draft[i] = 8'h00;
      end else if ($urandom_range(3) != 0) begin
        draft[i] = SEQ_ALPHABET[8 * $urandom_range(7) +: 8];
      end else begin
        draft[i] = 8'($urandom);
      end
    end
    return n;
  endfunction

  // One random phase. Half of the work is replaying catalog entries as key
  // sequences; the rest is new entries and noise (stray bytes, zero bytes,
  // ticks and spare-mode items). Every queued item counts toward the total.
  task automatic fill_phase(input int n_items, input int tmo);
    int made;
    int roll;
    int k;
    int p;
    int n;
    made = 0;
    while (made < n_items) begin
      roll = $urandom_range(99);
      if (roll < 50 && cat_total > 0) begin
        k = $urandom_range(cat_total - 1);
        p = ($urandom_range(9) < 7) ? cat_len[k] : $urandom_range(cat_len[k], 1);
        for (int i = 0; i < p; i++) begin
          queue_item(MODE_KEY, cat_bytes[k][i], 8'($urandom), 1'($urandom));
          made++;
          if (i < p - 1) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
              // Ticks short of the timeout keep the sequence alive.
              n = (tmo > 1) ? $urandom_range((tmo > 6) ? 6 : tmo - 1) : 0;
              repeat (n) queue_item(MODE_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
              made += n;
            end else if (roll < 19 && cat_total < MAX_ENTRIES) begin
              // A load between key bytes applies at the next search.
              n = compose_entry(3);
              queue_entry(n, 8'($urandom));
              made += n;
            end else if (roll < 21) begin
              queue_item(MODE_SPARE, 8'($urandom), 8'($urandom), 1'($urandom));
              made++;
            end
          end
        end
        if (p < cat_len[k]) begin
          // A cut-short sequence ends by timeout, by a zero byte or by a
          // byte that breaks the match.
          roll = $urandom_range(99);
          if (roll < 45 && tmo <= 12) begin
            n = ((tmo == 0) ? 1 : tmo) + $urandom_range(1);
            repeat (n) begin
              queue_item(MODE_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
            end
            made += n;
          end else if (roll < 75) begin
            queue_item(MODE_KEY, 8'h00, 8'($urandom), 1'($urandom));
            made++;
          end else begin
            queue_item(MODE_KEY, 8'($urandom_range(255, 1)), 8'($urandom), 1'($urandom));
            made++;
          end
        end
      end else if (roll < 65) begin
        n = compose_entry(MAX_SEQ_LEN + 1);
        made += n;
        queue_entry(n, 8'($urandom));
      end else begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          queue_item(MODE_KEY, ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom),
                     8'($urandom), 1'($urandom));
          made++;
        end else if (roll < 85) begin
          queue_item(MODE_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
          made++;
        end else begin
          queue_item(MODE_SPARE, 8'($urandom), 8'($urandom), 1'($urandom));
          made++;
        end
      end
    end
  endtask

  // The register is written only with the core idle, one cycle of cfg_we.
  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Waits until every item has been transferred, every key code has come
  // back and the core has dropped busy, then gives a search time to settle.
  task automatic drain();
    do @(posedge clk);
    while (item_q.size() != 0 || start || expected_keys.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge. A new item is presented when
  // the previous one was transferred at the last rising edge, or when start
  // is low; in each such cycle the sender stays idle with chance idle_pct.
  // item_taken is set by the monitor at the rising edge of a transfer.
  // --------------------------------------------------------------------------
  bit item_taken = 1'b0;

  always @(negedge clk) begin : driver
    key_item_t it;
    if (!rst && (!start || item_taken)) begin
      if (item_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        it = item_q.pop_front();
        mode        <= it.md;
        data_byte   <= it.data;
        target_code <= it.target;
        entry_end   <= it.commit;
        start       <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
    item_taken = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor. At each rising edge it first checks a key code transfer against
  // the oldest expectation, then feeds the model with an item transfer made
  // at the same edge. A key code is registered and always trails its cause,
  // so this order never compares against an expectation made too late.
  // --------------------------------------------------------------------------
  int items_taken = 0;
  int keys_seen   = 0;
  int table_hits  = 0;
  int fail_count  = 0;

  always @(posedge clk) begin : monitor
    key_result_t want;
    if (!rst) begin
      if (key_valid) begin
        keys_seen++;
        if (from_table) table_hits++;
        if (expected_keys.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: key code transfer with none expected, key_code %02h from_table %0b",
                     $time, key_code, from_table);
          end
        end else begin
          want = expected_keys.pop_front();
          if (key_code !== want.code) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: key_code expected %02h actual %02h", $time, want.code, key_code);
            end
          end
          if (from_table !== want.hit) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: from_table expected %0b actual %0b", $time, want.hit, from_table);
            end
          end
        end
      end
      if (cfg_we) timeout_reg = cfg_wdata;
      if (start && !busy) begin
        item_taken = 1'b1;
        items_taken++;
        predict_item(mode, data_byte, target_code, entry_end);
      end
    end
  end

  // Guard against a hung core or a lost key code.
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d key codes still outstanding",
             LIMIT_CYCLES, expected_keys.size());
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int tmo;

    // Directed opening, with the timeout still at its reset value.
    queue_item(MODE_KEY, 8'h00, 8'hFF, 1'b1);    // zero byte while idle
    queue_item(MODE_TICK, 8'hFF, 8'h00, 1'b0);   // tick while idle is dropped
    queue_item(MODE_SPARE, 8'hFF, 8'hFF, 1'b1);  // spare mode is dropped
    queue_item(MODE_KEY, 8'hFF, 8'h00, 1'b0);    // empty table, raw byte
    set_draft(80'h1B5B41, 3);                    // cursor up
    queue_entry(3, 8'h80);
    set_draft(80'h1B4F01020304050607, 9);        // overlong, last two bytes dropped
    queue_entry(9, 8'hFF);
    set_draft(80'h1B0033, 3);                    // zero byte inside an entry
    queue_entry(3, 8'h01);
    queue_item(MODE_KEY, 8'h1B, 8'h00, 1'b0);    // full match with a tick inside
    queue_item(MODE_KEY, 8'h5B, 8'h00, 1'b0);
    queue_item(MODE_TICK, 8'h00, 8'h00, 1'b0);
    queue_item(MODE_KEY, 8'h41, 8'h00, 1'b0);
    queue_item(MODE_KEY, 8'h1B, 8'h00, 1'b0);    // zero byte while waiting
    queue_item(MODE_KEY, 8'h00, 8'h00, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain();

    // Random phases. Each one starts from an idle core with a new timeout
    // and sender gap rate. The receiver cannot hold off key codes, so the
    // phase meant for receiver stalls runs without sender gaps, and the
    // mixed phase keeps only the sender half. A closing zero byte flushes
    // any sequence still waiting so that the next register write is clean.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       begin tmo = 3;                     idle_pct = 0;  end
        1:       begin tmo = 1;                     idle_pct = 62; end
        2:       begin tmo = 65535;                 idle_pct = 0;  end
        3:       begin tmo = 0;                     idle_pct = 23; end
        default: begin tmo = $urandom_range(9, 2);  idle_pct = 62; end
      endcase
      write_timeout(16'(tmo));
      fill_phase(PHASE_ITEMS, tmo);
      queue_item(MODE_KEY, 8'h00, 8'($urandom), 1'($urandom));
      drain();
    end

    $display("Covered %0d item transfers, %0d key codes (%0d from the table), %0d entries",
             items_taken, keys_seen, table_hits, seq_total);
    $display("loaded; timeouts 500, 3, 1, 65535, 0 and one random; %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : tb_key_sequence_prefix_matcher_core
`default_nettype wire

// ----- filelist.f -----
rtl/core/kspm_pkg.sv
rtl/core/kspm_ram.sv
rtl/core/key_sequence_prefix_matcher_core.sv
rtl/core/kspm_checker.sv
dv/tb_key_sequence_prefix_matcher_core.sv
